// ----- hw/rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int TAG_WIDTH  = 16;
  localparam int PRIO_WIDTH = 3;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  typedef logic [TAG_WIDTH-1:0]  tag_t;
  typedef logic [PRIO_WIDTH-1:0] prio_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    FN_ENQ = 1'b0,
    FN_DEQ = 1'b1
  } func_t;

  typedef struct packed {
    logic  valid;
    tag_t  tag;
    prio_t prio;
  } entry_t;

  typedef struct packed {
    logic  enq;
    logic  deq;
    tag_t  tag;
    prio_t prio;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/spq_if.sv -----
`default_nettype none
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  spq_pkg::tag_t      tag_in;
  spq_pkg::prio_t     prio_in;

  modport source (output valid, func, tag_in, prio_in, input ready);
  modport sink   (input valid, func, tag_in, prio_in, output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  spq_pkg::status_t   status;
  spq_pkg::tag_t      tag_out;
  spq_pkg::prio_t     prio_out;
  spq_pkg::count_t    fill;

  modport source (output valid, status, tag_out, prio_out, fill, input ready);
  modport sink   (input valid, status, tag_out, prio_out, fill, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
`default_nettype none
module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spq_pkg::cmd_t   cmd,
  input  wire spq_pkg::entry_t left,
  input  wire logic            left_keep,
  input  wire spq_pkg::entry_t right,
  output spq_pkg::entry_t      q,
  output logic                 keep
);

  logic           valid_r, valid_nxt;
  spq_pkg::tag_t  tag_r, tag_nxt;
  spq_pkg::prio_t prio_r, prio_nxt;

  // entry stays put on enqueue when it outranks or ties the new one
  assign keep = valid_r && (prio_r >= cmd.prio);
  assign q    = '{valid: valid_r, tag: tag_r, prio: prio_r};

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    if (cmd.enq && !keep) begin
      if (left_keep) begin
        valid_nxt = 1'b1;
        tag_nxt   = cmd.tag;
        prio_nxt  = cmd.prio;
      end else begin
        valid_nxt = left.valid;
        tag_nxt   = left.tag;
        prio_nxt  = left.prio;
      end
    end else if (cmd.deq) begin
      valid_nxt = right.valid;
      tag_nxt   = right.tag;
      prio_nxt  = right.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/spq_chain.sv -----
`default_nettype none
module spq_chain (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire spq_pkg::cmd_t   cmd,
  output spq_pkg::entry_t      head
);

  spq_pkg::entry_t q    [spq_pkg::CAPACITY];
  logic            keep [spq_pkg::CAPACITY];

  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_keep;

    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = q[i-1];
      assign left_keep = keep[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = q[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .left      (left),
      .left_keep (left_keep),
      .right     (right),
      .q         (q[i]),
      .keep      (keep[i])
    );
  end

  assign head = q[0];

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_priority_queue_top.sv -----
`default_nettype none
// latency: result is registered and shown the cycle after the input transfer
// throughput: one operation per cycle while the result is taken; every cell of the row updates on one edge
// the result register frees as it is taken, so a new item can enter as the waiting one is taken
// reset: synchronous, active low; clears entry count, cell valid bits, result valid
// stored tags and priorities are not cleared and no clearing pass is needed
module sorted_priority_queue_top (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  spq_pkg::count_t  count_r, count_nxt;
  logic             out_valid_r;
  spq_pkg::status_t status_r, status_nxt;
  spq_pkg::tag_t    tag_r, tag_nxt;
  spq_pkg::prio_t   prio_r, prio_nxt;
  spq_pkg::count_t  fill_r;

  logic             xfer, is_full, is_empty;
  spq_pkg::cmd_t    cmd;
  spq_pkg::entry_t  head;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign is_full     = (count_r == spq_pkg::count_t'(spq_pkg::CAPACITY));
  assign is_empty    = (count_r == '0);

  always_comb begin
    cmd.enq    = xfer && (in_ch.func == spq_pkg::FN_ENQ) && !is_full;
    cmd.deq    = xfer && (in_ch.func == spq_pkg::FN_DEQ) && !is_empty;
    cmd.tag    = in_ch.tag_in;
    cmd.prio   = in_ch.prio_in;
    count_nxt  = count_r;
    status_nxt = spq_pkg::ST_OK;
    tag_nxt    = '0;
    prio_nxt   = '0;
    if (in_ch.func == spq_pkg::FN_ENQ) begin
      if (is_full) begin
        status_nxt = spq_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = spq_pkg::ST_EMPTY;
      end else begin
        count_nxt = count_r - 1'b1;
        tag_nxt   = head.tag;
        prio_nxt  = head.prio;
      end
    end
  end

  spq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        count_r <= count_nxt;
      end
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      status_r <= status_nxt;
      tag_r    <= tag_nxt;
      prio_r   <= prio_nxt;
      fill_r   <= count_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.tag_out  = tag_r;
  assign out_ch.prio_out = prio_r;
  assign out_ch.fill     = fill_r;

`ifndef NO_ASSERTIONS
  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid == (count_r != '0))
    else $error("head valid disagrees with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::count_t'(spq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == spq_pkg::ST_FULL) |->
      fill_r == spq_pkg::count_t'(spq_pkg::CAPACITY))
    else $error("full status without full fill");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> fill_r == count_r)
    else $error("reported fill differs from entry count");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int PRIO_MAX    = (1 << spq_pkg::PRIO_WIDTH) - 1;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_LIMIT = 2000;

  typedef struct {
    spq_pkg::status_t status;
    spq_pkg::tag_t    tag;
    spq_pkg::prio_t   prio;
    spq_pkg::count_t  fill;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the sorted array
  spq_pkg::tag_t  shadow_tags  [spq_pkg::CAPACITY];
  spq_pkg::prio_t shadow_prios [spq_pkg::CAPACITY];
  int             shadow_count = 0;

  queue_result_t awaited_results[$];

  int mismatches     = 0;
  int enq_accepted   = 0;
  int enq_refused    = 0;
  int deq_served     = 0;
  int deq_empty      = 0;
  int max_fill_seen  = 0;
  bit steady_source  = 1'b0;
  bit steady_sink    = 1'b0;
  int hold_requests  = 0;

  function automatic queue_result_t apply_queue_op(spq_pkg::func_t op, spq_pkg::tag_t tag,
                                                   spq_pkg::prio_t prio);
    queue_result_t r;
    int slot;
    int i;
    r.status = spq_pkg::ST_OK;
    r.tag    = '0;
    r.prio   = '0;
    if (op == spq_pkg::FN_ENQ) begin
      if (shadow_count >= spq_pkg::CAPACITY) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // insert behind every entry of equal or higher priority
        slot = shadow_count;
        while (slot > 0 && prio > shadow_prios[slot-1]) begin
          shadow_tags[slot]  = shadow_tags[slot-1];
          shadow_prios[slot] = shadow_prios[slot-1];
          slot--;
        end
        shadow_tags[slot]  = tag;
        shadow_prios[slot] = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.tag  = shadow_tags[0];
      r.prio = shadow_prios[0];
      for (i = 1; i < shadow_count; i++) begin
        shadow_tags[i-1]  = shadow_tags[i];
        shadow_prios[i-1] = shadow_prios[i];
      end
      shadow_count--;
    end
    r.fill = spq_pkg::count_t'(shadow_count);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    queue_result_t want;
    queue_result_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: status %0d tag %h prio %0d fill %0d",
                 out_ch.status, out_ch.tag_out, out_ch.prio_out, out_ch.fill);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.tag_out !== want.tag) begin
            $error("tag_out: expected %h, actual %h", want.tag, out_ch.tag_out);
            mismatches++;
          end
          if (out_ch.prio_out !== want.prio) begin
            $error("prio_out: expected %0d, actual %0d", want.prio, out_ch.prio_out);
            mismatches++;
          end
          if (out_ch.fill !== want.fill) begin
            $error("fill: expected %0d, actual %0d", want.fill, out_ch.fill);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = apply_queue_op(spq_pkg::func_t'(in_ch.func), in_ch.tag_in, in_ch.prio_in);
        awaited_results.push_back(pred);
        if (pred.status == spq_pkg::ST_FULL) enq_refused++;
        else if (pred.status == spq_pkg::ST_EMPTY) deq_empty++;
        else if (spq_pkg::func_t'(in_ch.func) == spq_pkg::FN_ENQ) enq_accepted++;
        else deq_served++;
        if (shadow_count > max_fill_seen) max_fill_seen = shadow_count;
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    int holds_started;
    hold_left = 0;
    holds_started = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_started) begin
        holds_started = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady_sink) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic offer_op(input spq_pkg::func_t op, input spq_pkg::tag_t tag,
                          input spq_pkg::prio_t prio);
    int gap;
    gap = 0;
    while (!steady_source && gap < 8 && $urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= op;
    in_ch.tag_in  <= tag;
    in_ch.prio_in <= prio;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_until_drained();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (awaited_results.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic test_directed();
    spq_pkg::tag_t  fill_tags  [spq_pkg::CAPACITY] = '{
      16'h0000, 16'hFFFF, 16'h1111, 16'h2222,
      16'h3333, 16'hAAAA, 16'h5555, 16'h8001,
      16'h7FFE, 16'h0F0F, 16'hF0F0, 16'h1234,
      16'hFEDC, 16'h00FF, 16'hFF00, 16'hC3C3};
    spq_pkg::prio_t fill_prios [spq_pkg::CAPACITY] = '{
      3'd0, 3'd7, 3'd3, 3'd3, 3'd7, 3'd0, 3'd5, 3'd1,
      3'd6, 3'd3, 3'd2, 3'd4, 3'd7, 3'd0, 3'd6, 3'd3};
    int i;
    offer_op(spq_pkg::FN_DEQ, 16'hFFFF, 3'd7);
    for (i = 0; i < spq_pkg::CAPACITY; i++) begin
      offer_op(spq_pkg::FN_ENQ, fill_tags[i], fill_prios[i]);
    end
    offer_op(spq_pkg::FN_ENQ, 16'hBEEF, 3'd7);
    repeat (5) offer_op(spq_pkg::FN_DEQ, 16'h0000, 3'd0);
    pause_until_drained();
  endtask

  task automatic test_random_phases(input int n_items);
    int sent;
    int len;
    int enq_pct;
    int lo;
    int hi;
    spq_pkg::func_t op;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(10, 60);
      case ($urandom_range(2))
        0: enq_pct = 80;
        1: enq_pct = 20;
        default: enq_pct = 50;
      endcase
      // narrow priority bands produce many ties
      if ($urandom_range(1)) begin
        lo = $urandom_range(PRIO_MAX - 1);
        hi = lo + 1;
      end else begin
        lo = 0;
        hi = PRIO_MAX;
      end
      repeat (len) begin
        op = ($urandom_range(99) < enq_pct) ? spq_pkg::FN_ENQ : spq_pkg::FN_DEQ;
        offer_op(op, spq_pkg::tag_t'($urandom), spq_pkg::prio_t'($urandom_range(hi, lo)));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int i;
    steady_source = 1'b1;
    hold_requests++;
    for (i = 0; i < 40; i++) begin
      offer_op((i % 4 == 3) ? spq_pkg::FN_DEQ : spq_pkg::FN_ENQ, spq_pkg::tag_t'($urandom),
               spq_pkg::prio_t'($urandom_range(PRIO_MAX)));
    end
    steady_source = 1'b0;
    pause_until_drained();
  endtask

  task automatic test_steady_stream();
    steady_source = 1'b1;
    steady_sink   = 1'b1;
    test_random_phases(150);
    steady_source = 1'b0;
    steady_sink   = 1'b0;
  endtask

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= spq_pkg::FN_ENQ;
    in_ch.tag_in  <= '0;
    in_ch.prio_in <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phases(440);
    test_backpressure();
    test_steady_stream();
    test_random_phases(440);

    pause_until_drained();
    repeat (4) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end

    $display("run covered %0d enqueues accepted, %0d refused as full, max fill %0d",
             enq_accepted, enq_refused, max_fill_seen);
    $display("and %0d dequeues served, %0d on an empty queue, %0d field mismatches",
             deq_served, deq_empty, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
